// ===== hw/rtl/tlbpt_pkg.sv =====
// shared constants, types and state encoding for the tlb page translation unit
`default_nettype none

package tlbpt_pkg;

    // address split: page number above the offset
    localparam int ADDR_WIDTH   = 20;
    localparam int OFFSET_WIDTH = 10;
    localparam int PAGE_WIDTH   = ADDR_WIDTH - OFFSET_WIDTH;
    localparam int FRAME_WIDTH  = PAGE_WIDTH;
    localparam int PAGE_COUNT   = 1 << PAGE_WIDTH;
    localparam int COUNT_WIDTH  = 32;

    // default tlb depth handed to the top level
    localparam int TLB_ENTRIES_DEFAULT = 16;

    // stream word widths, padded to whole bytes
    localparam int IN_DATA_WIDTH  = ((ADDR_WIDTH + 7) / 8) * 8;
    localparam int OUT_RAW_WIDTH  = ADDR_WIDTH + 3 * COUNT_WIDTH;
    localparam int OUT_DATA_WIDTH = ((OUT_RAW_WIDTH + 7) / 8) * 8;
    localparam int OUT_PAD_WIDTH  = OUT_DATA_WIDTH - OUT_RAW_WIDTH;
    localparam int OUT_USER_WIDTH = 2;

    // controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic clear_en;
        logic load;
        logic finish;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tlbpt_ctrl.sv =====
// controller state machine: table clearing pass, word accept and lookup sequencing
`default_nettype none

module tlbpt_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire tlbpt_pkg::dp_status_t  status,
    output tlbpt_pkg::ctrl_cmd_t        cmd
);

    tlbpt_pkg::state_t state_reg;
    tlbpt_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlbpt_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tlbpt_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = tlbpt_pkg::ST_IDLE;
                end
            end
            tlbpt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tlbpt_pkg::ST_LOOKUP;
                end
            end
            tlbpt_pkg::ST_LOOKUP:
            begin
                if (status.out_free)
                begin
                    state_next = tlbpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tlbpt_pkg::ST_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready     = 1'b0;
        cmd.clear_en = 1'b0;
        cmd.load     = 1'b0;
        cmd.finish   = 1'b0;
        unique case (state_reg)
            tlbpt_pkg::ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
            end
            tlbpt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            tlbpt_pkg::ST_LOOKUP:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tlbpt_datapath.sv =====
// datapath: tlb cam, page table memory, frame allocator, counters, output register
`default_nettype none

module tlbpt_datapath #(
    parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEFAULT
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire tlbpt_pkg::ctrl_cmd_t                  cmd,
    output tlbpt_pkg::dp_status_t                      status,
    input  wire logic [tlbpt_pkg::ADDR_WIDTH-1:0]      in_addr,
    input  wire logic                                  out_ready,
    output logic                                       out_valid,
    output logic [tlbpt_pkg::OUT_DATA_WIDTH-1:0]       out_data,
    output logic [tlbpt_pkg::OUT_USER_WIDTH-1:0]       out_user
);

    localparam int SLOT_WIDTH = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int PW = tlbpt_pkg::PAGE_WIDTH;
    localparam int FW = tlbpt_pkg::FRAME_WIDTH;
    localparam int OW = tlbpt_pkg::OFFSET_WIDTH;
    localparam int AW = tlbpt_pkg::ADDR_WIDTH;
    localparam int CW = tlbpt_pkg::COUNT_WIDTH;

    // latched address
    logic [AW-1:0] va_reg;
    logic [PW-1:0] page;
    logic [OW-1:0] offset;

    // tlb entries
    logic [PW-1:0]          tlb_tag_reg   [TLB_ENTRIES];
    logic [FW-1:0]          tlb_frame_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] tlb_valid_reg;
    logic [SLOT_WIDTH-1:0]  tlb_slot_reg;
    logic [SLOT_WIDTH-1:0]  tlb_slot_next;

    // page table memory, word is {valid, frame}
    logic [FW:0]   table_mem [tlbpt_pkg::PAGE_COUNT];
    logic [FW:0]   table_rd_reg;
    logic          table_we;
    logic [PW-1:0] table_wa;
    logic [FW:0]   table_wd;
    logic [PW-1:0] clr_idx_reg;

    // allocator and counters
    logic [FW-1:0] free_frame_reg;
    logic [CW-1:0] total_cnt_reg;
    logic [CW-1:0] hit_cnt_reg;
    logic [CW-1:0] fault_cnt_reg;
    logic [CW-1:0] total_cnt_next;
    logic [CW-1:0] hit_cnt_next;
    logic [CW-1:0] fault_cnt_next;

    // lookup results
    logic          hit;
    logic [FW-1:0] hit_frame;
    logic          fault;
    logic [FW-1:0] frame;

    // output register
    logic                                 out_valid_reg;
    logic [tlbpt_pkg::OUT_DATA_WIDTH-1:0] out_data_reg;
    logic [tlbpt_pkg::OUT_USER_WIDTH-1:0] out_user_reg;

    assign page   = va_reg[AW-1:OW];
    assign offset = va_reg[OW-1:0];

    // parallel tag compare, lowest matching slot wins
    always_comb
    begin
        hit       = 1'b0;
        hit_frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (tlb_valid_reg[i] && (tlb_tag_reg[i] == page))
            begin
                hit       = 1'b1;
                hit_frame = tlb_frame_reg[i];
            end
        end
    end

    // miss handling: mapped frame or next free frame
    always_comb
    begin
        fault = !hit && !table_rd_reg[FW];
        priority if (hit)
        begin
            frame = hit_frame;
        end
        else if (table_rd_reg[FW])
        begin
            frame = table_rd_reg[FW-1:0];
        end
        else
        begin
            frame = free_frame_reg;
        end
    end

    // saturating counts including the current word
    always_comb
    begin
        total_cnt_next = (total_cnt_reg == '1) ? total_cnt_reg : total_cnt_reg + 1'b1;
        hit_cnt_next   = hit_cnt_reg;
        fault_cnt_next = fault_cnt_reg;
        if (hit && (hit_cnt_reg != '1))
        begin
            hit_cnt_next = hit_cnt_reg + 1'b1;
        end
        if (fault && (fault_cnt_reg != '1))
        begin
            fault_cnt_next = fault_cnt_reg + 1'b1;
        end
    end

    // fifo replacement pointer
    assign tlb_slot_next = (tlb_slot_reg == SLOT_WIDTH'(TLB_ENTRIES - 1)) ?
                           '0 : tlb_slot_reg + 1'b1;

    // page table write port: clearing pass or fault fill
    assign table_we = cmd.clear_en || (cmd.finish && fault);
    assign table_wa = cmd.clear_en ? clr_idx_reg : page;
    assign table_wd = cmd.clear_en ? '0 : {1'b1, frame};

    // page table memory
    always_ff @(posedge clk)
    begin
        if (table_we)
        begin
            table_mem[table_wa] <= table_wd;
        end
        if (cmd.load)
        begin
            table_rd_reg <= table_mem[in_addr[AW-1:OW]];
        end
    end

    // address latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            va_reg <= in_addr;
        end
    end

    // tlb tag and frame fill
    always_ff @(posedge clk)
    begin
        if (cmd.finish && !hit)
        begin
            tlb_tag_reg[tlb_slot_reg]   <= page;
            tlb_frame_reg[tlb_slot_reg] <= frame;
        end
    end

    // control state: valid bits, pointers, counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlb_valid_reg  <= '0;
            tlb_slot_reg   <= '0;
            clr_idx_reg    <= '0;
            free_frame_reg <= '0;
            total_cnt_reg  <= '0;
            hit_cnt_reg    <= '0;
            fault_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.clear_en)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                total_cnt_reg <= total_cnt_next;
                hit_cnt_reg   <= hit_cnt_next;
                fault_cnt_reg <= fault_cnt_next;
                if (!hit)
                begin
                    tlb_valid_reg[tlb_slot_reg] <= 1'b1;
                    tlb_slot_reg                <= tlb_slot_next;
                end
                if (fault)
                begin
                    free_frame_reg <= free_frame_reg + 1'b1;
                end
            end
        end
    end

    // output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg <= {{tlbpt_pkg::OUT_PAD_WIDTH{1'b0}}, fault_cnt_next,
                             hit_cnt_next, total_cnt_next, frame, offset};
            out_user_reg <= {fault, hit};
        end
    end

    assign status.clear_last = cmd.clear_en && (clr_idx_reg == '1);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tlb_page_translation_unit.sv =====
// top level of the tlb page translation unit: controller plus datapath
`default_nettype none

// Translates one 20-bit virtual address per input word into a physical address
// (frame in the upper 10 bits, offset passed through), flags a tlb hit or a page
// fault, and reports saturating running counts of translations, hits and faults.
// Each address is handled in an accept step and a lookup step: the accept step
// issues the registered page table read, and the lookup step compares all tlb
// entries in parallel, resolves the frame, updates tlb (fifo replacement), page
// table and counters, and loads the output register. The next address is taken
// once the lookup step is done; a result waiting in the output register holds
// back only the lookup step of the next address. After reset the page table is
// cleared one entry per cycle, and no input word is accepted until that is done.

module tlb_page_translation_unit #(
    parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEFAULT
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // slave side
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // [19:0] virtual_address
    input  wire logic [tlbpt_pkg::IN_DATA_WIDTH-1:0]   s_tdata,
    // master side
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // [19:0] phys_addr, [51:20] translated_count,
    // [83:52] hit_count, [115:84] fault_count
    output logic [tlbpt_pkg::OUT_DATA_WIDTH-1:0]       m_tdata,
    // [0] tlb_hit, [1] page_fault
    output logic [tlbpt_pkg::OUT_USER_WIDTH-1:0]       m_tuser
);

    tlbpt_pkg::ctrl_cmd_t  cmd;
    tlbpt_pkg::dp_status_t status;

    // sequencing
    tlbpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // translation datapath
    tlbpt_datapath #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_addr   (s_tdata[tlbpt_pkg::ADDR_WIDTH-1:0]),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule

`default_nettype wire
